>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the gap buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, quiet while reset is applied
`define GB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication that must hold in the cycle after its trigger
`define GB_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared sizes, opcodes and status codes of the gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  // store size and derived widths
  localparam int CAPACITY = 1024;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CHAR_W   = 8;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_MOVE   = 2'd1,
    OP_READ   = 2'd2
  } opcode_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

endpackage

>>> src/gbts_ram.sv
// ----------------------------------------------------------------------------
// gbts_ram
// Simple dual-port character store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/gap_buffer_text_store.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed-capacity gap buffer of characters with insert, cursor move and read.
//
// channel  | direction | handshake        | payload
// ---------+-----------+------------------+------------------------------------
// command  | in        | start, busy      | opcode_i, char_in_i, position_i
// result   | out       | done_o (strobe)  | char_out_o, status_o,
//          |           |                  | text_length_o, cursor_o
//
// A command is taken when start is high and busy is low; busy stays high
// until the result strobe. Insert and unused opcodes finish in the execute
// state, a read adds a registered store read (skipped when the index is past
// the text), and a cursor move alternates store read and write steps: the
// single store port pair copies one character across the gap per read/write
// step pair. The result strobe follows in the next cycle.
// Reset empties the text; the store itself is not cleared. The receiver
// cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gap_buffer_text_store
  import gbts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [CHAR_W-1:0] char_in_i,
  input  logic [CNT_W-1:0]  position_i,
  output logic              done_o,
  output logic [CHAR_W-1:0] char_out_o,
  output logic [ST_W-1:0]   status_o,
  output logic [CNT_W-1:0]  text_length_o,
  output logic [CNT_W-1:0]  cursor_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_MV_RD,
    S_MV_WR
  } state_e;

  state_e              state_q;
  logic [OP_W-1:0]     opcode_q;
  logic [CHAR_W-1:0]   char_q;
  logic [CNT_W-1:0]    pos_q;
  logic [CNT_W-1:0]    target_q;
  logic [CNT_W-1:0]    before_q;
  logic [CNT_W-1:0]    after_q;
  logic                done_q;
  logic [CHAR_W-1:0]   char_out_q;
  status_e             status_q;

  logic [CNT_W-1:0]    len;
  logic [CNT_W-1:0]    hi_start;
  logic [CNT_W-1:0]    read_idx;
  logic                fwd;
  logic                accept;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [CHAR_W-1:0]   wdata;
  logic [ADDR_W-1:0]   raddr;
  logic [CHAR_W-1:0]   rdata;

  // text bookkeeping
  assign len      = before_q + after_q;
  assign hi_start = CAP_CNT - after_q;
  assign read_idx = (pos_q >= before_q) ? (hi_start + (pos_q - before_q)) : pos_q;
  assign fwd      = (target_q > before_q);
  assign accept   = start && !busy;

  // store port steering
  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(before_q);
    wdata = char_q;
    raddr = ADDR_W'(read_idx);
    unique case (state_q)
      S_EXEC: begin
        we = (opcode_e'(opcode_q) == OP_INSERT) && (len < CAP_CNT);
      end
      S_MV_RD: begin
        raddr = fwd ? ADDR_W'(hi_start) : ADDR_W'(before_q - 1'b1);
      end
      S_MV_WR: begin
        we    = 1'b1;
        wdata = rdata;
        waddr = fwd ? ADDR_W'(before_q) : ADDR_W'(hi_start - 1'b1);
      end
      default: begin
      end
    endcase
  end

  gbts_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (CHAR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // command operands, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q <= opcode_i;
      char_q   <= char_in_i;
      pos_q    <= position_i;
    end
  end

  // sequencer: state, counts and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      before_q   <= '0;
      after_q    <= '0;
      target_q   <= '0;
      done_q     <= 1'b0;
      char_out_q <= '0;
      status_q   <= ST_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          char_out_q <= '0;
          status_q   <= ST_OK;
          case (opcode_e'(opcode_q))
            OP_INSERT: begin
              if (len >= CAP_CNT) begin
                status_q <= ST_FULL;
              end else begin
                before_q <= before_q + 1'b1;
              end
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
            OP_MOVE: begin
              if (pos_q > len) begin
                target_q <= len;
                status_q <= ST_RANGE;
              end else begin
                target_q <= pos_q;
              end
              state_q <= S_MV_RD;
            end
            OP_READ: begin
              if (pos_q >= len) begin
                status_q <= ST_RANGE;
                done_q   <= 1'b1;
                state_q  <= S_IDLE;
              end else begin
                state_q <= S_READ;
              end
            end
            default: begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          endcase
        end
        S_READ: begin
          char_out_q <= rdata;
          done_q     <= 1'b1;
          state_q    <= S_IDLE;
        end
        S_MV_RD: begin
          if (target_q == before_q) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MV_WR;
          end
        end
        S_MV_WR: begin
          if (fwd) begin
            before_q <= before_q + 1'b1;
            after_q  <= after_q - 1'b1;
          end else begin
            before_q <= before_q - 1'b1;
            after_q  <= after_q + 1'b1;
          end
          state_q <= S_MV_RD;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // outputs
  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign char_out_o    = char_out_q;
  assign status_o      = status_q;
  assign text_length_o = len;
  assign cursor_o      = before_q;

  // checks
  `GB_ASSERT(a_done_idle, !done_q || (state_q == S_IDLE), "result strobe while busy")
  `GB_ASSERT(a_len_cap, ({1'b0, before_q} + {1'b0, after_q}) <= {1'b0, CAP_CNT},
             "text length exceeds capacity")
  `GB_ASSERT(a_target_len, (state_q != S_MV_RD) || (target_q <= len),
             "move target beyond text length")
  `GB_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_q,
                  "accepted command did not make the block busy")

endmodule

>>> dv/gap_buffer_text_store_checker.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store_checker
// Watches the command and result channels of the gap buffer text store,
// keeps its own copy of the store and the gap counts, predicts the result
// of every accepted command and compares each result strobe against it.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_checker
  import gbts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [CHAR_W-1:0] char_in_i,
  input  logic [CNT_W-1:0]  position_i,
  input  logic              done_i,
  input  logic [CHAR_W-1:0] char_out_i,
  input  logic [ST_W-1:0]   status_i,
  input  logic [CNT_W-1:0]  text_length_i,
  input  logic [CNT_W-1:0]  cursor_i,
  output int                fail_count_o,
  output int                pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    status_e           st;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  cur;
  } edit_result_t;

  // shadow store: text before the gap at the bottom, text after it at the top
  logic [CHAR_W-1:0] shadow_mem [CAPACITY];
  int unsigned       head_cnt;
  int unsigned       tail_cnt;

  edit_result_t expected_q [$];
  edit_result_t oldest;

  // apply one command to the shadow store and return its result
  function automatic edit_result_t apply_edit(logic [OP_W-1:0]   op,
                                              logic [CHAR_W-1:0] ch,
                                              logic [CNT_W-1:0]  pos);
    edit_result_t r;
    int unsigned  len;
    int unsigned  target;
    int unsigned  idx;
    r     = '0;
    r.st  = ST_OK;
    len   = head_cnt + tail_cnt;
    case (op)
      OP_INSERT: begin
        if (len >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          shadow_mem[head_cnt] = ch;
          head_cnt++;
        end
      end
      OP_MOVE: begin
        target = pos;
        if (target > len) begin
          target = len;
          r.st   = ST_RANGE;
        end
        // copy characters across the gap one at a time
        while (head_cnt < target) begin
          shadow_mem[head_cnt] = shadow_mem[CAPACITY - tail_cnt];
          head_cnt++;
          tail_cnt--;
        end
        while (head_cnt > target) begin
          head_cnt--;
          tail_cnt++;
          shadow_mem[CAPACITY - tail_cnt] = shadow_mem[head_cnt];
        end
      end
      OP_READ: begin
        if (pos >= len) begin
          r.st = ST_RANGE;
        end else begin
          // indexes at or past the cursor skip over the gap
          idx = pos;
          if (pos >= head_cnt) idx = pos + (CAPACITY - len);
          r.ch = shadow_mem[idx];
        end
      end
      default: ;
    endcase
    r.len = CNT_W'(head_cnt + tail_cnt);
    r.cur = CNT_W'(head_cnt);
    return r;
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  // results retire first, then a command transfer on the same edge is queued
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_cnt = 0;
      tail_cnt = 0;
      fail_count_o = 0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %0h/%0d/%0d/%0d",
                   $time, char_out_i, status_i, text_length_i, cursor_i);
          fail_count_o++;
        end else begin
          oldest = expected_q.pop_front();
          check_field("char_out", CNT_W'(oldest.ch), CNT_W'(char_out_i));
          check_field("status", CNT_W'(oldest.st), CNT_W'(status_i));
          check_field("text_length", oldest.len, text_length_i);
          check_field("cursor", oldest.cur, cursor_i);
        end
      end
      if (start_i && !busy_i) begin
        expected_q.insert(expected_q.size(), apply_edit(opcode_i, char_in_i, position_i));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> dv/gap_buffer_text_store_test.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store_test
// Drives insert, cursor move, read and unused commands into the gap buffer
// text store: a short directed run over empty, tiny and clamped cases, then
// random traffic that fills the store to capacity and keeps editing it.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_test
  import gbts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int              CLK_PERIOD   = 20;
  localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
  localparam int              FILL_MAX     = 1400;
  localparam int              EDIT_ITEMS   = 225;
  localparam int              IDLE_PCT     = 12;
  localparam int              DRAIN_CYCLES = 20;
  // every command as a full-distance move plus sender gaps, taken three times
  localparam longint          CYCLE_LIMIT  = 64'd12_000_000;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   opcode_i   = '0;
  logic [CHAR_W-1:0] char_in_i  = '0;
  logic [CNT_W-1:0]  position_i = '0;
  logic              done_o;
  logic [CHAR_W-1:0] char_out_o;
  logic [ST_W-1:0]   status_o;
  logic [CNT_W-1:0]  text_length_o;
  logic [CNT_W-1:0]  cursor_o;

  int     fail_count;
  int     pending;
  longint cycle_cnt = 0;

  // text length and cursor as seen by the stimulus, used to aim positions
  int text_len   = 0;
  int cursor_pos = 0;
  int idle_pct   = IDLE_PCT;

  gap_buffer_text_store u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .char_in_i    (char_in_i),
    .position_i   (position_i),
    .done_o       (done_o),
    .char_out_o   (char_out_o),
    .status_o     (status_o),
    .text_length_o(text_length_o),
    .cursor_o     (cursor_o)
  );

  gap_buffer_text_store_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .opcode_i     (opcode_i),
    .char_in_i    (char_in_i),
    .position_i   (position_i),
    .done_i       (done_o),
    .char_out_i   (char_out_o),
    .status_i     (status_o),
    .text_length_i(text_length_o),
    .cursor_i     (cursor_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("gap_buffer_text_store_test failed");
      $finish;
    end
  end

  // one command transfer, with an occasional idle gap before it
  task automatic send_command(logic [OP_W-1:0]   op,
                              logic [CHAR_W-1:0] ch,
                              logic [CNT_W-1:0]  pos);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    start      <= 1'b1;
    opcode_i   <= op;
    char_in_i  <= ch;
    position_i <= pos;
    do @(posedge clk_i); while (busy);
    // follow the text shape for aiming later positions
    if (op == OP_INSERT && text_len < CAPACITY) begin
      text_len++;
      cursor_pos++;
    end else if (op == OP_MOVE) begin
      cursor_pos = (int'(pos) > text_len) ? text_len : int'(pos);
    end
  endtask

  // random command with the given weights in percent; the rest are unused codes
  task automatic random_command(int ins_w, int mov_w, int rd_w);
    int              pick;
    int              aim;
    int              target;
    logic [OP_W-1:0] op;
    pick   = $urandom_range(99);
    target = $urandom_range(2047);
    if (pick < ins_w) begin
      op = OP_INSERT;
    end else if (pick < ins_w + mov_w) begin
      op  = OP_MOVE;
      aim = $urandom_range(99);
      if (aim < 70) begin
        // short hop around the cursor
        target = cursor_pos + int'($urandom_range(12)) - 6;
        if (target < 0) target = 0;
        if (target > text_len) target = text_len;
      end else if (aim < 90) begin
        target = $urandom_range(text_len);
      end else begin
        target = $urandom_range(2047, text_len);
      end
    end else if (pick < ins_w + mov_w + rd_w) begin
      op  = OP_READ;
      aim = $urandom_range(99);
      if (aim < 80 && text_len > 0) begin
        target = $urandom_range(text_len - 1);
      end else if (aim < 90) begin
        target = text_len;
      end else begin
        target = $urandom_range(2047, text_len);
      end
    end else begin
      op = OP_UNUSED;
    end
    send_command(op, CHAR_W'($urandom_range(255)), CNT_W'(target));
  endtask

  initial begin
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: read, moves in and out of range, unused code
    send_command(OP_READ, 8'h00, 11'd0);
    send_command(OP_MOVE, 8'h00, 11'd0);
    send_command(OP_MOVE, 8'h00, 11'h7FF);
    send_command(OP_UNUSED, 8'hFF, 11'h7FF);

    // a few characters at the extremes, then reads across and past the end
    send_command(OP_INSERT, 8'h00, 11'd0);
    send_command(OP_INSERT, 8'hFF, 11'h7FF);
    send_command(OP_INSERT, 8'hA5, 11'd0);
    for (int i = 0; i < 4; i++) send_command(OP_READ, 8'h00, CNT_W'(i));
    send_command(OP_READ, 8'h00, 11'h7FF);
    send_command(OP_READ, 8'h00, 11'h400);

    // insert in the middle, then read around the gap
    send_command(OP_MOVE, 8'h00, 11'd1);
    send_command(OP_INSERT, 8'h5A, 11'd0);
    for (int i = 0; i < 4; i++) send_command(OP_READ, 8'h00, CNT_W'(i));

    // moves back to the start, clamped past the end, and back into the text
    send_command(OP_MOVE, 8'h00, 11'd0);
    send_command(OP_MOVE, 8'h00, 11'h400);
    send_command(OP_MOVE, 8'h00, 11'd2);
    send_command(OP_UNUSED, 8'h00, 11'd0);
    send_command(OP_READ, 8'h00, 11'd4);
    send_command(OP_READ, 8'h00, 11'd2);

    // mostly inserts until the store is full, with a stretch of no idling
    n = 0;
    while (text_len < CAPACITY && n < FILL_MAX) begin
      idle_pct = (n >= 300 && n < 500) ? 0 : IDLE_PCT;
      random_command(85, 5, 8);
      n++;
    end

    // edit a full store: refused inserts, moves, reads and unused codes
    idle_pct = IDLE_PCT;
    for (int i = 0; i < EDIT_ITEMS; i++) random_command(20, 25, 50);
    start <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("gap_buffer_text_store_test passed");
    end else begin
      $display("gap_buffer_text_store_test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/gbts_pkg.sv
src/gbts_ram.sv
src/gap_buffer_text_store.sv
dv/gap_buffer_text_store_checker.sv
dv/gap_buffer_text_store_test.sv
